[rtl/core/ssm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the sparse set membership engine.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int NUM_ELEMENTS = 256;
    localparam int ELEM_W       = 8;
    localparam int ACT_W        = 2;
    localparam int POS_W        = $clog2(NUM_ELEMENTS);
    localparam int COUNT_W      = $clog2(NUM_ELEMENTS + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_QUERY  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CHOOSE = 2'd3
    } action_t;

    // One-hot sequencer states
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_CHECK = 5'b01000,
        S_SWAP  = 5'b10000
    } state_t;

endpackage

[rtl/core/ssm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/sparse_set_membership_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_set_membership_engine
// Sparse set of 8-bit transition indices with query, insert, remove, choose.
// ----------------------------------------------------------------------------
// The set lives in two RAMs: a position table indexed by element and a member
// table indexed by slot, plus a member count register. An element belongs to
// the set only when its claimed slot is below the count and that slot names it
// back, so the membership logic works with any table contents. Even so, both
// RAMs are zeroed by a clearing pass after reset, one entry per cycle, and
// in_ready stays low until it ends. One transaction is worked on at a time.
// For query, insert, choose and a remove that misses, the sequencer issues
// the position read on accept, then the member read, then loads the result;
// a remove that hits adds a read of the last member and a swap step before
// the result. These steps follow from the chain of dependent reads through the
// single read port of each table (position, then member for the cross-check,
// then the last member for the swap). A new transaction is accepted as soon as
// the sequencer is idle, even while the previous result still waits in the
// output register; the sequencer only stalls at its final step until that
// register is free.
// ----------------------------------------------------------------------------
module sparse_set_membership_engine
    import ssm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ACT_W-1:0]   action,
    input  logic [ELEM_W-1:0]  element,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok,
    output logic [ELEM_W-1:0]  chosen,
    output logic [COUNT_W-1:0] member_count
);

    // Sequencer and latched transaction
    state_t               state_reg, state_next;
    action_t              act_reg;
    logic [ELEM_W-1:0]    elem_reg;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]     clr_idx_reg;

    // Result register
    logic                 out_valid_reg;
    logic                 ok_reg, ok_next;
    logic [ELEM_W-1:0]    chosen_reg, chosen_next;
    logic [COUNT_W-1:0]   mcount_reg;

    // Table ports
    logic                 pos_we, pos_re;
    logic [POS_W-1:0]     pos_waddr, pos_wdata, pos_raddr, pos_q;
    logic                 mem_we, mem_re;
    logic [POS_W-1:0]     mem_waddr, mem_raddr;
    logic [ELEM_W-1:0]    mem_wdata, mem_q;

    logic                 accept;
    logic                 out_free;
    logic                 res_load;
    logic                 hit;
    logic [COUNT_W-1:0]   count_m1;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign count_m1 = count_reg - COUNT_W'(1);

    // Cross-check: claimed slot is live and names the element back
    assign hit = (COUNT_W'(pos_q) < count_reg) && (mem_q == elem_reg);

    ssm_ram #(
        .DEPTH (NUM_ELEMENTS),
        .WIDTH (POS_W)
    ) u_position_of (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_q)
    );

    ssm_ram #(
        .DEPTH (NUM_ELEMENTS),
        .WIDTH (ELEM_W)
    ) u_member_at (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    // Position lookup is issued on accept
    assign pos_re    = accept;
    assign pos_raddr = POS_W'(element);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        res_load    = 1'b0;
        ok_next     = 1'b0;
        chosen_next = '0;
        pos_we      = 1'b0;
        pos_waddr   = POS_W'(elem_reg);
        pos_wdata   = count_reg[POS_W-1:0];
        mem_we      = 1'b0;
        mem_waddr   = count_reg[POS_W-1:0];
        mem_wdata   = elem_reg;
        mem_re      = 1'b0;
        mem_raddr   = pos_q;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Zero one entry of each table per cycle
                pos_we    = 1'b1;
                pos_waddr = clr_idx_reg;
                pos_wdata = '0;
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (clr_idx_reg == POS_W'(NUM_ELEMENTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                // Member read: slot zero for choose, claimed slot otherwise
                mem_re = 1'b1;
                if (act_reg == ACT_CHOOSE)
                begin
                    mem_raddr = '0;
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (act_reg == ACT_REMOVE && hit)
                begin
                    // Fetch the last member for the swap
                    mem_re     = 1'b1;
                    mem_raddr  = count_m1[POS_W-1:0];
                    state_next = S_SWAP;
                end
                else if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    unique case (act_reg)
                        ACT_QUERY:
                        begin
                            ok_next = hit;
                        end
                        ACT_INSERT:
                        begin
                            if (!hit && count_reg < COUNT_W'(NUM_ELEMENTS))
                            begin
                                ok_next    = 1'b1;
                                pos_we     = 1'b1;
                                mem_we     = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        ACT_CHOOSE:
                        begin
                            if (count_reg != '0)
                            begin
                                ok_next     = 1'b1;
                                chosen_next = mem_q;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            ok_next = 1'b0;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_SWAP:
            begin
                if (out_free)
                begin
                    // Last member moves into the freed slot
                    mem_we     = 1'b1;
                    mem_waddr  = pos_q;
                    mem_wdata  = mem_q;
                    pos_we     = 1'b1;
                    pos_waddr  = POS_W'(mem_q);
                    pos_wdata  = pos_q;
                    count_next = count_m1;
                    ok_next    = 1'b1;
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            count_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + POS_W'(1);
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action_t'(action);
            elem_reg <= element;
        end
        if (res_load)
        begin
            ok_reg     <= ok_next;
            chosen_reg <= chosen_next;
            mcount_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign chosen       = chosen_reg;
    assign member_count = mcount_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(NUM_ELEMENTS))
        else $error("member count above table size");

    a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(res_load))
        else $error("member count changed without a result");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (out_valid_reg && mcount_reg == count_reg))
        else $error("reported member count differs from state");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second transaction accepted while busy");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse set membership engine.
// ----------------------------------------------------------------------------
// Every transaction accepted on the input side is run through a local sparse
// set (slot table, member table and live count, held at the block's widths).
// The answer is queued. Each transaction leaving the block is compared field
// by field with the oldest queued answer. The run covers a short directed
// sequence, a full fill and drain of the table, a long receiver hold-off and
// random traffic under four idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import ssm_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [ELEM_W-1:0]  chosen;
        logic [COUNT_W-1:0] member_count;
    } answer_t;

    // Generous ceiling; a correct run ends far sooner.
    localparam int RUN_LIMIT_NS = 5_000_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [ACT_W-1:0]   action;
    logic [ELEM_W-1:0]  element;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               ok;
    logic [ELEM_W-1:0]  chosen;
    logic [COUNT_W-1:0] member_count;

    sparse_set_membership_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .element      (element),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ok           (ok),
        .chosen       (chosen),
        .member_count (member_count)
    );

    // 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Local copy of the set. Slots at or above the live count are never read
    // for a decision, so clearing the tables here need not match the RAMs.
    // ------------------------------------------------------------------------
    logic [POS_W-1:0]   slot_of    [NUM_ELEMENTS];
    logic [ELEM_W-1:0]  element_in [NUM_ELEMENTS];
    logic [COUNT_W-1:0] live_count;

    answer_t answers_due[$];
    answer_t due_answer;
    answer_t seen_answer;
    bit      failed = 1'b0;

    // Knobs shared by the stimulus and the receiver
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  holding        = 1'b0;

    function automatic bit is_member(input logic [ELEM_W-1:0] e);
        logic [POS_W-1:0] p;
        p = slot_of[e];
        return ({1'b0, p} < live_count) && (element_in[p] == e);
    endfunction

    // Applies one transaction to the local set and returns its answer.
    function automatic answer_t set_apply(input action_t a, input logic [ELEM_W-1:0] e);
        answer_t          r;
        logic [POS_W-1:0] p;
        logic [ELEM_W-1:0] last;
        r = '0;
        case (a)
            ACT_QUERY:
                r.ok = is_member(e);
            ACT_INSERT:
                if (!is_member(e) && live_count < COUNT_W'(NUM_ELEMENTS))
                begin
                    slot_of[e] = live_count[POS_W-1:0];
                    element_in[live_count[POS_W-1:0]] = e;
                    live_count = live_count + COUNT_W'(1);
                    r.ok = 1'b1;
                end
            ACT_REMOVE:
                if (is_member(e))
                begin
                    // last member moves into the freed slot
                    p = slot_of[e];
                    live_count = live_count - COUNT_W'(1);
                    last = element_in[live_count[POS_W-1:0]];
                    element_in[p] = last;
                    slot_of[last] = p;
                    r.ok = 1'b1;
                end
            default:
                if (live_count != '0)
                begin
                    r.ok = 1'b1;
                    r.chosen = element_in[0];
                end
        endcase
        r.member_count = live_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and scoreboard: both handshakes sampled at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            answers_due.push_back(set_apply(action_t'(action), element));
        if (rst_n && out_valid && out_ready)
        begin
            seen_answer = '{ok: ok, chosen: chosen, member_count: member_count};
            if (answers_due.size() == 0)
            begin
                $error("result transaction with nothing outstanding: ok=%0d chosen=%0d count=%0d",
                       ok, chosen, member_count);
                failed = 1'b1;
            end
            else
            begin
                due_answer = answers_due.pop_front();
                if (seen_answer.ok !== due_answer.ok)
                begin
                    $error("ok: expected %0d, got %0d", due_answer.ok, seen_answer.ok);
                    failed = 1'b1;
                end
                if (seen_answer.chosen !== due_answer.chosen)
                begin
                    $error("chosen: expected %0d, got %0d",
                           due_answer.chosen, seen_answer.chosen);
                    failed = 1'b1;
                end
                if (seen_answer.member_count !== due_answer.member_count)
                begin
                    $error("member_count: expected %0d, got %0d",
                           due_answer.member_count, seen_answer.member_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver: random stalls, forced low during a hold-off.
    always @(negedge clk)
    begin
        if (holding)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Holds the receiver off for a number of cycles, counted here.
    task automatic hold_receiver(input int cycles);
        @(posedge clk);
        holding = 1'b1;
        repeat (cycles) @(posedge clk);
        holding = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sender: drives at the falling edge, holds until the transaction is taken.
    // ------------------------------------------------------------------------
    task automatic send_op(input action_t a, input logic [ELEM_W-1:0] e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= a;
        element  <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drops valid and lets every outstanding result drain.
    task automatic drain;
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edge cases on a small set: empty choose, misses, duplicate insert,
    // a remove that swaps the last member down, removal of the last member.
    task automatic test_directed;
        send_op(ACT_CHOOSE, 8'd0);
        send_op(ACT_QUERY,  8'd0);
        send_op(ACT_REMOVE, 8'd0);
        send_op(ACT_INSERT, 8'd0);
        send_op(ACT_INSERT, 8'd255);
        send_op(ACT_INSERT, 8'd0);
        send_op(ACT_QUERY,  8'd255);
        send_op(ACT_QUERY,  8'd0);
        send_op(ACT_QUERY,  8'd128);
        send_op(ACT_CHOOSE, 8'd77);
        send_op(ACT_REMOVE, 8'd0);
        send_op(ACT_CHOOSE, 8'd0);
        send_op(ACT_QUERY,  8'd0);
        send_op(ACT_REMOVE, 8'd255);
        send_op(ACT_REMOVE, 8'd255);
        send_op(ACT_CHOOSE, 8'd0);
        send_op(ACT_INSERT, 8'd170);
        send_op(ACT_INSERT, 8'd85);
        send_op(ACT_REMOVE, 8'd85);
        send_op(ACT_CHOOSE, 8'd0);
        send_op(ACT_QUERY,  8'd170);
        send_op(ACT_REMOVE, 8'd170);
        drain();
    endtask

    // Fills the whole table in shuffled order, pokes it while full, then
    // empties it in another shuffled order.
    task automatic test_fill_and_empty;
        logic [ELEM_W-1:0] order [NUM_ELEMENTS];
        logic [ELEM_W-1:0] tmp;
        int                j;
        for (int i = 0; i < NUM_ELEMENTS; i++)
            order[i] = ELEM_W'(i);
        for (int i = NUM_ELEMENTS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < NUM_ELEMENTS; i++)
            send_op(ACT_INSERT, order[i]);
        // full table: every insert is refused
        send_op(ACT_INSERT, order[0]);
        send_op(ACT_INSERT, ELEM_W'($urandom_range(255)));
        send_op(ACT_CHOOSE, 8'd0);
        for (int i = 0; i < 8; i++)
            send_op(ACT_QUERY, ELEM_W'($urandom_range(255)));
        for (int i = NUM_ELEMENTS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < NUM_ELEMENTS; i++)
        begin
            send_op(ACT_REMOVE, order[i]);
            if ($urandom_range(7) == 0)
                send_op(ACT_CHOOSE, 8'd0);
        end
        send_op(ACT_REMOVE, order[0]);
        send_op(ACT_CHOOSE, 8'd0);
        drain();
    endtask

    // Receiver held off for a long stretch while the sender keeps offering,
    // so the output register and then the input side back up.
    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            hold_receiver(80);
        join_none
        for (int i = 0; i < 24; i++)
            send_op(action_t'($urandom_range(3)), ELEM_W'($urandom_range(15)));
        drain();
    endtask

    // Random traffic; most elements come from a small hot set so that
    // inserts, hits and swaps happen often, the rest span the full range.
    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        logic [ELEM_W-1:0] hot [16];
        int                pick;
        action_t           a;
        logic [ELEM_W-1:0] e;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < 16; i++)
            hot[i] = ELEM_W'($urandom_range(255));
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 32)
                a = ACT_INSERT;
            else if (pick < 57)
                a = ACT_REMOVE;
            else if (pick < 87)
                a = ACT_QUERY;
            else
                a = ACT_CHOOSE;
            if ($urandom_range(3) != 0)
                e = hot[$urandom_range(15)];
            else
                e = ELEM_W'($urandom_range(255));
            send_op(a, e);
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        in_valid = 1'b0;
        action   = ACT_QUERY;
        element  = '0;
        rst_n    = 1'b0;
        for (int i = 0; i < NUM_ELEMENTS; i++)
        begin
            slot_of[i]    = '0;
            element_in[i] = '0;
        end
        live_count = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_fill_and_empty();
        test_backpressure();
        test_random(225, 0, 0);
        test_random(225, 63, 0);
        test_random(225, 0, 63);
        test_random(225, 16, 16);

        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #RUN_LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
